[src/u8u16_pkg.sv]
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  // register index, taken from paddr[2]
  localparam logic RegAddBom = 1'b0;

  localparam logic [7:0]  HdrByte0  = 8'hEF;
  localparam logic [7:0]  HdrByte1  = 8'hBB;
  localparam logic [7:0]  HdrByte2  = 8'hBF;
  localparam logic [15:0] BomUnit   = 16'hFEFF;
  localparam logic [20:0] SurrBase  = 21'h10000;
  localparam logic [15:0] HiSurr    = 16'hD800;
  localparam logic [15:0] LoSurr    = 16'hDC00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_string;
    logic       last_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        end_of_string;
    logic        well_formed;
    logic        last_of_item;
  } res_item_t;

  // work handed from the classifier to the emitter
  typedef struct packed {
    logic        bom;
    logic [1:0]  unit_cnt;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;
    logic        last;
    logic        ok;
  } job_t;

endpackage

[src/u8u16_front.sv]
// byte classifier: sequence decode, header tracking, surrogate split
module u8u16_front import u8u16_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  logic     add_bom_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  logic [20:0] code_q, code_d;
  logic [1:0]  left_q, left_d;
  logic [1:0]  pos_q, pos_d;
  logic        match_q, match_d;
  logic        ok_q, ok_d;

  logic [7:0]  b;
  logic        first, last;
  logic [20:0] code;
  logic [1:0]  left;
  logic [1:0]  pos;
  logic        match;
  logic        ok;
  logic        hit;
  logic        have;
  logic        drop;
  logic [20:0] cp;
  logic [20:0] v;
  logic [1:0]  cnt;

  assign b     = item_i.data_byte;
  assign first = item_i.first_of_string;
  assign last  = item_i.last_of_string;

  always_comb begin
    code  = code_q;
    left  = left_q;
    pos   = pos_q;
    match = match_q;
    ok    = ok_q;
    have  = 1'b0;
    cp    = '0;
    if (first) begin
      code  = '0;
      left  = '0;
      pos   = '0;
      match = 1'b1;
      ok    = 1'b1;
    end

    hit = match && ((pos == 2'd0 && b == HdrByte0) ||
                    (pos == 2'd1 && b == HdrByte1) ||
                    (pos == 2'd2 && b == HdrByte2));

    if (left != 2'd0) begin
      code = {code[14:0], b[5:0]};
      left = left - 2'd1;
      if (left == 2'd0) begin
        have = 1'b1;
        cp   = code;
      end
    end else if (!b[7]) begin
      have = 1'b1;
      cp   = {13'd0, b};
    end else if (b[7:6] == 2'b10) begin
      ok = 1'b0;
    end else if (b[7:5] == 3'b110) begin
      code = {16'd0, b[4:0]};
      left = 2'd1;
    end else if (b[7:4] == 4'hE) begin
      code = {17'd0, b[3:0]};
      left = 2'd2;
    end else begin
      code = {18'd0, b[2:0]};
      left = 2'd3;
    end

    // truncated sequence: missing continuations read as zero
    if (last && left != 2'd0) begin
      case (left)
        2'd1:    code = {code[14:0], 6'd0};
        2'd2:    code = {code[8:0], 12'd0};
        default: code = {code[2:0], 18'd0};
      endcase
      left = '0;
      have = 1'b1;
      cp   = code;
    end

    drop = hit && pos == 2'd2 && !last;

    cnt = 2'd0;
    if (have && !drop) begin
      cnt = (cp >= SurrBase) ? 2'd2 : 2'd1;
    end
    v = cp - SurrBase;

    job_o.bom      = first && add_bom_i;
    job_o.unit_cnt = cnt;
    job_o.unit_hi  = (cnt == 2'd2) ? (HiSurr | {5'd0, v[20:10]}) : cp[15:0];
    job_o.unit_lo  = LoSurr | {6'd0, v[9:0]};
    job_o.last     = last;
    job_o.ok       = ok;
    job_valid_o    = accept_i && (job_o.bom || cnt != 2'd0 || last);

    code_d  = have ? '0 : code;
    left_d  = left;
    pos_d   = (pos == 2'd3) ? pos : pos + 2'd1;
    match_d = (pos >= 2'd2) ? 1'b0 : hit;
    ok_d    = ok;
    if (last) begin
      code_d  = '0;
      left_d  = '0;
      pos_d   = '0;
      match_d = 1'b0;
      ok_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      left_q  <= '0;
      pos_q   <= '0;
      match_q <= 1'b0;
      ok_q    <= 1'b1;
    end else if (accept_i) begin
      code_q  <= code_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      match_q <= match_d;
      ok_q    <= ok_d;
    end
  end

endmodule

[src/u8u16_fifo.sv]
// small register queue of decoded jobs
module u8u16_fifo import u8u16_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output job_t rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[src/u8u16_back.sv]
// emitter: expands each job into one to three result items
module u8u16_back import u8u16_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_rd_o,
  input  logic      pop_i,
  output logic      empty_o,
  output res_item_t res_o
);

  logic [1:0] k_q, k_d;
  logic       out_valid_q, out_valid_d;
  res_item_t  res_q, res_d;

  logic [1:0]  n;
  logic [1:0]  j;
  logic        bare;
  logic        final_res;
  logic        load;
  logic [15:0] unit;

  always_comb begin
    n         = {1'b0, job_i.bom} + job_i.unit_cnt;
    bare      = (n == 2'd0);
    final_res = bare || (k_q == n - 2'd1);
    j         = k_q - {1'b0, job_i.bom};
    if (job_i.bom && k_q == 2'd0) begin
      unit = BomUnit;
    end else if (j == 2'd0) begin
      unit = job_i.unit_hi;
    end else begin
      unit = job_i.unit_lo;
    end

    res_d.code_unit     = bare ? 16'd0 : unit;
    res_d.unit_valid    = !bare;
    res_d.end_of_string = final_res && job_i.last;
    res_d.well_formed   = final_res && job_i.last && job_i.ok;
    res_d.last_of_item  = final_res;

    load        = !job_empty_i && (!out_valid_q || pop_i);
    job_rd_o    = load && final_res;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      k_d         = final_res ? 2'd0 : k_q + 2'd1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;

endmodule

[src/utf8_to_utf16_transcoder_top.sv]
// utf-8 to utf-16 transcoder, top level
//
// Input queue side: one utf-8 byte per item with first/last string markers,
// taken when push is high and full is low. Result queue side: utf-16 code
// units, the oldest on result_o while empty is low, taken on pop.
// A classifier decodes each byte in the cycle it is accepted and writes a
// job into a short queue; an emitter expands every job into one to three
// result items (optional bom, a unit or a surrogate pair, or a bare end
// marker) through a single output register.
// A decoded job is written into the job queue, then loaded into the output register.
// Throughput: one byte per cycle while bytes yield at most one unit and the
// queue is not full; the emitter gives one result per cycle while results are
// popped, so a bom or a surrogate pair needs an extra result, absorbed by the
// job queue. Reset clears the decode state, the job queue and the output
// valid flag; add_bom resets to 0. When pop is held low the output register
// holds and the queue fills, then full rises and input stalls; no item is lost.
// add_bom is written through the apb port at address 0, bit 0.
module utf8_to_utf16_transcoder_top import u8u16_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            item_i,
  output logic                empty,
  input  logic                pop,
  output res_item_t           result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic add_bom_q;
  logic accept;
  logic job_valid;
  job_t job_wr, job_rd;
  logic job_empty;
  logic job_rd_en;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegAddBom);
  assign prdata = (paddr[2] == RegAddBom) ? {{(ApbDataW-1){1'b0}}, add_bom_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_bom_q <= 1'b0;
    end else if (cfg_wr) begin
      add_bom_q <= pwdata[0];
    end
  end

  assign accept = push && !full;

  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .add_bom_i   (add_bom_q),
    .job_valid_o (job_valid),
    .job_o       (job_wr)
  );

  u8u16_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_valid),
    .wr_data_i (job_wr),
    .full_o    (full),
    .rd_en_i   (job_rd_en),
    .rd_data_o (job_rd),
    .empty_o   (job_empty)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_rd),
    .job_empty_i (job_empty),
    .job_rd_o    (job_rd_en),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (result_o)
  );

endmodule

[src/u8u16_checker.sv]
// port-level checks of the transcoder result stream
module u8u16_checker import u8u16_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input res_item_t result_o
);

  // a waiting result is not withdrawn or changed while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while stalled");

  // a bare marker carries no unit and closes both the byte and the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.unit_valid) |->
      (result_o.code_unit == 16'd0 && result_o.end_of_string && result_o.last_of_item))
    else $error("malformed bare end marker");

  // well_formed only reported on the end of a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.well_formed) |-> result_o.end_of_string)
    else $error("well_formed outside end of string");

  // the end of a string is always the last result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.end_of_string) |-> result_o.last_of_item)
    else $error("end of string not last of item");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_checker (.*);
